/* hdl/jsu_pkg.sv */
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_WAIT,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX1,
    MODE_BS,
    MODE_U,
    MODE_HEX2,
    MODE_SKIP
  } mode_t;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
  localparam logic [2:0] ERR_CONTROL      = 3'd1;
  localparam logic [2:0] ERR_ESCAPE       = 3'd2;
  localparam logic [2:0] ERR_HEX          = 3'd3;
  localparam logic [2:0] ERR_LONE_LOW     = 3'd4;
  localparam logic [2:0] ERR_NO_PAIR      = 3'd5;
  localparam logic [2:0] ERR_BAD_LOW      = 3'd6;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd7;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      ndata;
    logic            has_term;
    logic [1:0]      term_kind;
    logic [2:0]      term_code;
  } cmd_t;

endpackage

/* hdl/jsu_front.sv */
// Decoder front end: accepts raw bytes and turns each into at most one queued command.
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          cmd_valid,
  output jsu_pkg::cmd_t cmd
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic [9:0]  high_r, high_nxt;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] unit_new;
  logic        unit_low;
  logic        unit_high;
  logic [20:0] pair_cp;
  logic [20:0] enc_cp;
  logic [3:0][7:0] enc_bytes;
  logic [2:0]  enc_n;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_val = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign unit_new  = {unit_r[11:0], hex_val};
  assign unit_low  = (unit_new >= 16'hdc00) && (unit_new <= 16'hdfff);
  assign unit_high = (unit_new >= 16'hd800) && (unit_new <= 16'hdbff);
  assign pair_cp   = 21'h10000 + {1'b0, high_r, unit_new[9:0]};
  assign enc_cp    = (mode_r == jsu_pkg::MODE_HEX1) ? {5'd0, unit_new} : pair_cp;

  always_comb begin
    enc_bytes = '0;
    if (enc_cp <= 21'h7f) begin
      enc_n        = 3'd1;
      enc_bytes[0] = enc_cp[7:0];
    end else if (enc_cp <= 21'h7ff) begin
      enc_n        = 3'd2;
      enc_bytes[0] = {3'b110, enc_cp[10:6]};
      enc_bytes[1] = {2'b10, enc_cp[5:0]};
    end else if (enc_cp <= 21'hffff) begin
      enc_n        = 3'd3;
      enc_bytes[0] = {4'b1110, enc_cp[15:12]};
      enc_bytes[1] = {2'b10, enc_cp[11:6]};
      enc_bytes[2] = {2'b10, enc_cp[5:0]};
    end else begin
      enc_n        = 3'd4;
      enc_bytes[0] = {5'b11110, enc_cp[20:18]};
      enc_bytes[1] = {2'b10, enc_cp[17:12]};
      enc_bytes[2] = {2'b10, enc_cp[11:6]};
      enc_bytes[3] = {2'b10, enc_cp[5:0]};
    end
  end

  // Next state.
  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    unit_nxt    = unit_r;
    high_nxt    = high_r;
    case (mode_r)
      jsu_pkg::MODE_WAIT: begin
        mode_nxt = (in_byte == 8'h22) ? jsu_pkg::MODE_BODY : jsu_pkg::MODE_SKIP;
      end
      jsu_pkg::MODE_BODY: begin
        if (in_byte == 8'h22 || in_byte < 8'h20) begin
          mode_nxt = jsu_pkg::MODE_SKIP;
        end else if (in_byte == 8'h5c) begin
          mode_nxt = jsu_pkg::MODE_ESC;
        end
      end
      jsu_pkg::MODE_ESC: begin
        case (in_byte)
          8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74: begin
            mode_nxt = jsu_pkg::MODE_BODY;
          end
          8'h75: begin
            mode_nxt    = jsu_pkg::MODE_HEX1;
            hex_cnt_nxt = 2'd0;
            unit_nxt    = 16'd0;
          end
          default: begin
            mode_nxt = jsu_pkg::MODE_SKIP;
          end
        endcase
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (!hex_ok) begin
          mode_nxt = jsu_pkg::MODE_SKIP;
        end else begin
          unit_nxt = unit_new;
          if (hex_cnt_r != 2'd3) begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end else begin
            hex_cnt_nxt = 2'd0;
            if (mode_r == jsu_pkg::MODE_HEX1) begin
              if (unit_low) begin
                mode_nxt = jsu_pkg::MODE_SKIP;
              end else if (unit_high) begin
                high_nxt = unit_new[9:0];
                mode_nxt = jsu_pkg::MODE_BS;
              end else begin
                mode_nxt = jsu_pkg::MODE_BODY;
              end
            end else begin
              mode_nxt = unit_low ? jsu_pkg::MODE_BODY : jsu_pkg::MODE_SKIP;
            end
          end
        end
      end
      jsu_pkg::MODE_BS: begin
        mode_nxt = (in_byte == 8'h5c) ? jsu_pkg::MODE_U : jsu_pkg::MODE_SKIP;
      end
      jsu_pkg::MODE_U: begin
        if (in_byte == 8'h75) begin
          mode_nxt    = jsu_pkg::MODE_HEX2;
          hex_cnt_nxt = 2'd0;
          unit_nxt    = 16'd0;
        end else begin
          mode_nxt = jsu_pkg::MODE_SKIP;
        end
      end
      default: begin
        mode_nxt = jsu_pkg::MODE_SKIP;
      end
    endcase
  end

  // Command for the current byte.
  always_comb begin
    cmd = '0;
    case (mode_r)
      jsu_pkg::MODE_WAIT: begin
        if (in_byte != 8'h22) begin
          cmd.has_term  = 1'b1;
          cmd.term_kind = jsu_pkg::KIND_ERROR;
          cmd.term_code = jsu_pkg::ERR_NO_QUOTE;
        end
      end
      jsu_pkg::MODE_BODY: begin
        if (in_byte == 8'h22) begin
          cmd.has_term  = 1'b1;
          cmd.term_kind = jsu_pkg::KIND_CLOSED;
        end else if (in_byte < 8'h20) begin
          cmd.has_term  = 1'b1;
          cmd.term_kind = jsu_pkg::KIND_ERROR;
          cmd.term_code = jsu_pkg::ERR_CONTROL;
        end else if (in_byte != 8'h5c) begin
          cmd.ndata   = 3'd1;
          cmd.data[0] = in_byte;
        end
      end
      jsu_pkg::MODE_ESC: begin
        cmd.ndata = 3'd1;
        case (in_byte)
          8'h22, 8'h5c, 8'h2f: cmd.data[0] = in_byte;
          8'h62: cmd.data[0] = 8'h08;
          8'h66: cmd.data[0] = 8'h0c;
          8'h6e: cmd.data[0] = 8'h0a;
          8'h72: cmd.data[0] = 8'h0d;
          8'h74: cmd.data[0] = 8'h09;
          8'h75: cmd.ndata   = 3'd0;
          default: begin
            cmd.ndata     = 3'd0;
            cmd.has_term  = 1'b1;
            cmd.term_kind = jsu_pkg::KIND_ERROR;
            cmd.term_code = jsu_pkg::ERR_ESCAPE;
          end
        endcase
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (!hex_ok) begin
          cmd.has_term  = 1'b1;
          cmd.term_kind = jsu_pkg::KIND_ERROR;
          cmd.term_code = jsu_pkg::ERR_HEX;
        end else if (hex_cnt_r == 2'd3) begin
          if (mode_r == jsu_pkg::MODE_HEX1) begin
            if (unit_low) begin
              cmd.has_term  = 1'b1;
              cmd.term_kind = jsu_pkg::KIND_ERROR;
              cmd.term_code = jsu_pkg::ERR_LONE_LOW;
            end else if (!unit_high) begin
              cmd.ndata = enc_n;
              cmd.data  = enc_bytes;
            end
          end else if (unit_low) begin
            cmd.ndata = enc_n;
            cmd.data  = enc_bytes;
          end else begin
            cmd.has_term  = 1'b1;
            cmd.term_kind = jsu_pkg::KIND_ERROR;
            cmd.term_code = jsu_pkg::ERR_BAD_LOW;
          end
        end
      end
      jsu_pkg::MODE_BS: begin
        if (in_byte != 8'h5c) begin
          cmd.has_term  = 1'b1;
          cmd.term_kind = jsu_pkg::KIND_ERROR;
          cmd.term_code = jsu_pkg::ERR_NO_PAIR;
        end
      end
      jsu_pkg::MODE_U: begin
        if (in_byte != 8'h75) begin
          cmd.has_term  = 1'b1;
          cmd.term_kind = jsu_pkg::KIND_ERROR;
          cmd.term_code = jsu_pkg::ERR_NO_PAIR;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
    if (in_last && mode_nxt != jsu_pkg::MODE_SKIP) begin
      cmd.has_term  = 1'b1;
      cmd.term_kind = jsu_pkg::KIND_ERROR;
      cmd.term_code = jsu_pkg::ERR_UNTERMINATED;
    end
  end

  assign cmd_valid = byte_valid && (cmd.has_term || cmd.ndata != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= jsu_pkg::MODE_WAIT;
      hex_cnt_r <= 2'd0;
      unit_r    <= 16'd0;
      high_r    <= 10'd0;
    end else if (byte_valid) begin
      if (in_last) begin
        mode_r    <= jsu_pkg::MODE_WAIT;
        hex_cnt_r <= 2'd0;
        unit_r    <= 16'd0;
        high_r    <= 10'd0;
      end else begin
        mode_r    <= mode_nxt;
        hex_cnt_r <= hex_cnt_nxt;
        unit_r    <= unit_nxt;
        high_r    <= high_nxt;
      end
    end
  end

endmodule

/* hdl/jsu_fifo.sv */
// Short command queue between the decoder front end and the result sequencer.
module jsu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  jsu_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output jsu_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  jsu_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count_r == DEPTH_C);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count exceeds its depth");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("command written into a full queue");

endmodule

/* hdl/jsu_back.sv */
// Result sequencer: expands each queued command into its result beats.
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jsu_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  logic          pop,
  output logic          empty,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_byte,
  output logic [2:0]    out_error_code,
  output logic          out_last
);

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       take;

  assign total = cmd.ndata + {2'b00, cmd.has_term};
  assign empty = cmd_empty;
  assign take  = pop && !cmd_empty;

  always_comb begin
    out_kind       = jsu_pkg::KIND_DATA;
    out_byte       = 8'd0;
    out_error_code = 3'd0;
    if (idx_r < cmd.ndata) begin
      out_byte = cmd.data[idx_r[1:0]];
    end else begin
      out_kind = cmd.term_kind;
      if (cmd.term_kind == jsu_pkg::KIND_ERROR) begin
        out_error_code = cmd.term_code;
      end
    end
  end

  assign out_last = (idx_r == total - 3'd1);
  assign cmd_pop  = take && out_last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = out_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_empty |-> idx_r < total)
    else $error("result index runs past the command");

  a_command_holds: assert property (@(posedge clk) disable iff (!rst_n)
    take && !out_last |=> !cmd_empty)
    else $error("command left the queue before its last beat");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_empty |-> out_kind != 2'd3)
    else $error("undefined result kind");

endmodule

/* hdl/json_string_unescape.sv */
// JSON string unescaper top level: byte decoder, command queue and result sequencer.
// One text byte is taken per clock whenever full is low; full rises only when the
// DEPTH-entry command queue between the decoder and the result sequencer is full.
// Each byte yields zero to five result beats, and the sequencer hands out one beat
// per clock while pop is high and the queue holds a command, while the decoder
// keeps going. A byte's results are output once its command is queued and every
// earlier command has been popped. Each text must open with a double quote and ends
// at the byte flagged by in_last, after which the decoder is ready for the next text.
module json_string_unescape #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  jsu_pkg::cmd_t wr_cmd;
  jsu_pkg::cmd_t rd_cmd;
  logic          wr_valid;
  logic          q_empty;
  logic          q_pop;
  logic          byte_valid;

  assign byte_valid = push && !full;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(byte_valid),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cmd_valid (wr_valid),
    .cmd       (wr_cmd)
  );

  jsu_fifo #(
    .DEPTH(DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_valid),
    .wr_data(wr_cmd),
    .full   (full),
    .rd_en  (q_pop),
    .rd_data(rd_cmd),
    .empty  (q_empty)
  );

  jsu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (rd_cmd),
    .cmd_empty     (q_empty),
    .cmd_pop       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_kind      (out_kind),
    .out_byte      (out_byte),
    .out_error_code(out_error_code),
    .out_last      (out_last)
  );

endmodule
